// ===== sv/rtttl_note_parser_assert.svh =====
// ----------------------------------------------------------------------------
// rtttl note parser assertion macros
// shared property forms for the note parser blocks
// ----------------------------------------------------------------------------
`ifndef RTTTL_NOTE_PARSER_ASSERT_SVH
`define RTTTL_NOTE_PARSER_ASSERT_SVH

// same-cycle implication
`define RTTTL_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rtttl: same-cycle check failed");

// next-cycle implication
`define RTTTL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rtttl: next-cycle check failed");

`endif

// ===== sv/rtttl_pkg.sv =====
// ----------------------------------------------------------------------------
// rtttl_pkg
// types, character codes and the semitone table of the note parser
// ----------------------------------------------------------------------------
`default_nettype none

package rtttl_pkg;

   // field widths
   localparam int TEMPO_W  = 10;
   localparam int DEN_W    = 8;
   localparam int OCT_W    = 4;
   localparam int FREQ_W   = 12;
   localparam int PERIOD_W = 17;
   localparam int TICKS_W  = 32;
   localparam int COUNT_W  = 16;
   localparam int DIV_W    = 19;   // tempo x denominator x 2
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP  = 2'd1;

   // character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SHARP = 8'h23;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_G     = 8'h67;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_DIGITS,
      PH_SHARP,
      PH_TAIL
   } parse_phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TONE,
      ST_TONE_WAIT,
      ST_DUR_WAIT,
      ST_LOAD
   } fsm_state_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // semitone frequencies in hz, octaves 2..7, c..b
   localparam int unsigned FREQ_TAB [6][12] = '{
      '{65, 69, 73, 78, 82, 87, 93, 98, 104, 110, 117, 123},
      '{131, 139, 147, 156, 165, 175, 185, 196, 208, 220, 233, 247},
      '{262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494},
      '{523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988},
      '{1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976},
      '{2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951}
   };

   // pitch lookup, zero for a rest, unknown letter or octave out of range
   function automatic logic [FREQ_W-1:0] pitch_hz(input logic [7:0] letter,
                                                  input logic sharp,
                                                  input logic [OCT_W-1:0] oct);
      logic [3:0] semi;
      logic [4:0] o;
      logic ok;
      logic [FREQ_W-1:0] f;
      semi = 4'd0;
      o = {1'b0, oct};
      ok = 1'b1;
      f = '0;
      case (letter)
         CH_C: semi = 4'd0;
         CH_D: semi = 4'd2;
         CH_E: semi = 4'd4;
         CH_F: semi = 4'd5;
         CH_G: semi = 4'd7;
         CH_A: semi = 4'd9;
         CH_B: semi = 4'd11;
         default: ok = 1'b0;
      endcase
      // b sharp wraps to c of the next octave
      if (sharp) begin
         if (semi == 4'd11) begin
            semi = 4'd0;
            o = o + 5'd1;
         end else begin
            semi = semi + 4'd1;
         end
      end
      if (ok && o >= 5'd2 && o <= 5'd7) begin
         f = FREQ_W'(FREQ_TAB[3'(o - 5'd2)][semi]);
      end
      return f;
   endfunction

endpackage

`default_nettype wire

// ===== sv/rtttl_div.sv =====
// ----------------------------------------------------------------------------
// rtttl_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rtttl_div #(
   parameter int NW = 39,
   parameter int DW = 19
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [NW-1:0]            num,
   input  wire logic [DW-1:0]            den,
   output logic [NW-1:0]                 quo,
   output rtttl_pkg::div_stat_type       stat
);

   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic [NW-1:0] quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;

   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          fits;
   logic [DW-1:0] rem_in;

   // trial subtract of the shifted remainder
   assign trial  = {rem_ff, quo_ff[NW-1]};
   assign diff   = trial - {1'b0, den_ff};
   assign fits   = trial >= {1'b0, den_ff};
   assign rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];

   // step counter and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= CW'(NW);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_ff - CW'(1);
         done_ff <= (cnt_ff == CW'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   // quotient and remainder shift
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[NW-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign quo       = quo_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

endmodule

`default_nettype wire

// ===== sv/rtttl_note_parser.sv =====
// Flow: a byte that closes no note is simply taken; a closing byte starts
// two passes of the shared one-bit-per-cycle divider, tone then length,
// before its word is loaded at the output.
// Throughput: one byte per cycle between notes; no byte is taken while a note
// is in work, and a word still held at the output stalls the input further.
// Reset: synchronous; tempo 120, header skip on, header phase, count zero.
// ----------------------------------------------------------------------------
// rtttl_note_parser
// streaming ringtone text parser giving tone period and note length
// ----------------------------------------------------------------------------
`default_nettype none
`include "rtttl_note_parser_assert.svh"

module rtttl_note_parser #(
   parameter int TIMER_HZ      = 100000000,
   parameter int TONE_CLOCK_HZ = 6250000
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // text input
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [7:0]                          req_text_byte,
   input  wire logic                                req_last_byte,
   // note output
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [rtttl_pkg::PERIOD_W-1:0]           rsp_tone_period,
   output logic [rtttl_pkg::TICKS_W-1:0]            rsp_duration_ticks,
   output logic                                     rsp_is_rest,
   output logic [rtttl_pkg::COUNT_W-1:0]            rsp_note_number,
   output logic                                     rsp_piece_end,
   // register writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rtttl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rtttl_pkg::TEMPO_W-1:0]       csr_wdata
);

   localparam logic [63:0] DUR_NUM1 = 64'(TIMER_HZ) * 64'd240;
   localparam logic [63:0] DUR_NUM3 = DUR_NUM1 * 64'd3;
   localparam int DUR_BITS  = $clog2(DUR_NUM3 + 64'd1);
   localparam int TONE_BITS = $clog2(64'(TONE_CLOCK_HZ) + 64'd2048);
   localparam int NUM_W     = (DUR_BITS > TONE_BITS) ? DUR_BITS : TONE_BITS;

   localparam int DEN_W  = rtttl_pkg::DEN_W;
   localparam int OCT_W  = rtttl_pkg::OCT_W;
   localparam int CNT_W  = rtttl_pkg::COUNT_W;
   localparam int DIV_W  = rtttl_pkg::DIV_W;
   localparam int FREQ_W = rtttl_pkg::FREQ_W;
   localparam int TEMPO_W = rtttl_pkg::TEMPO_W;

   // configuration
   logic [TEMPO_W-1:0] tempo_ff;
   logic               skip_ff;

   // parser state
   rtttl_pkg::parse_phase_type phase_ff, phase_in, ph_work;
   logic [1:0]        colons_ff, colons_in;
   logic [DEN_W-1:0]  den_ff, den_in, pd_den;
   logic [7:0]        letter_ff, letter_in, pd_letter;
   logic              sharp_ff, sharp_in, pd_sharp;
   logic              dot_ff, dot_in, pd_dot;
   logic [OCT_W-1:0]  oct_ff, oct_in, pd_oct;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ended, emit, do_tail, is_digit;
   logic [11:0]       dsum;

   // note under work
   logic [DEN_W-1:0]  w_den_ff;
   logic [7:0]        w_letter_ff;
   logic              w_sharp_ff, w_dot_ff;
   logic [OCT_W-1:0]  w_oct_ff;
   logic [CNT_W-1:0]  w_num_ff;
   logic              w_end_ff;

   // sequencer
   rtttl_pkg::fsm_state_type state_ff, state_in;
   logic                         div_start;
   logic [NUM_W-1:0]             div_num;
   logic [DIV_W-1:0]             div_den;
   logic [NUM_W-1:0]             div_quo;
   rtttl_pkg::div_stat_type      div_stat;
   logic                         cap_period, load_out;
   logic                         div_wait;

   // arithmetic operands
   logic [FREQ_W-1:0]  freq;
   logic [NUM_W-1:0]   tone_num, dur_num;
   logic [DEN_W-1:0]   den_eff;
   logic [17:0]        beat_prod;
   logic [DIV_W-1:0]   dur_div;
   logic [63:0]        quo_wide;
   logic [rtttl_pkg::PERIOD_W-1:0] period_ff, period_sat;
   logic [rtttl_pkg::TICKS_W-1:0]  ticks_sat;

   // output word
   logic                               rsp_valid_ff;
   logic [rtttl_pkg::PERIOD_W-1:0]     rsp_period_ff;
   logic [rtttl_pkg::TICKS_W-1:0]      rsp_ticks_ff;
   logic                               rsp_rest_ff;
   logic [CNT_W-1:0]                   rsp_num_ff;
   logic                               rsp_end_ff;

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tempo_ff <= TEMPO_W'(120);
         skip_ff  <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            rtttl_pkg::CSR_TEMPO: tempo_ff <= csr_wdata;
            rtttl_pkg::CSR_SKIP:  skip_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // byte classification
   assign ended    = (req_text_byte == rtttl_pkg::CH_NUL) || req_last_byte;
   assign is_digit = (req_text_byte >= rtttl_pkg::CH_ZERO) &&
                     (req_text_byte <= rtttl_pkg::CH_NINE);
   assign dsum     = 12'(den_ff) * 12'd10 + 12'(req_text_byte[3:0]);

   // byte parser, next state of the note fields
   always_comb begin
      ph_work   = phase_ff;
      phase_in  = phase_ff;
      colons_in = colons_ff;
      count_in  = count_ff;
      pd_den    = den_ff;
      pd_letter = letter_ff;
      pd_sharp  = sharp_ff;
      pd_dot    = dot_ff;
      pd_oct    = oct_ff;
      emit      = 1'b0;
      do_tail   = 1'b0;
      if (phase_ff == rtttl_pkg::PH_HEADER && skip_ff) begin
         // header skip up to the second colon
         if (ended) begin
            colons_in = 2'd0;
            count_in  = '0;
         end else if (req_text_byte == rtttl_pkg::CH_COLON) begin
            colons_in = colons_ff + 2'd1;
            if (colons_in >= 2'd2) begin
               phase_in = rtttl_pkg::PH_DIGITS;
            end
         end
      end else begin
         ph_work  = (phase_ff == rtttl_pkg::PH_HEADER) ? rtttl_pkg::PH_DIGITS : phase_ff;
         phase_in = ph_work;
         if (req_text_byte != rtttl_pkg::CH_NUL) begin
            case (ph_work)
               rtttl_pkg::PH_DIGITS: begin
                  if (is_digit) begin
                     pd_den = (dsum > 12'd255) ? 8'hff : dsum[7:0];
                  end else begin
                     pd_letter = req_text_byte;
                     phase_in  = rtttl_pkg::PH_SHARP;
                  end
               end
               rtttl_pkg::PH_SHARP: begin
                  phase_in = rtttl_pkg::PH_TAIL;
                  if (req_text_byte == rtttl_pkg::CH_SHARP) begin
                     pd_sharp = 1'b1;
                  end else begin
                     do_tail = 1'b1;
                  end
               end
               default: do_tail = 1'b1;
            endcase
         end
         // bytes after the letter: comma, dot, octave digit
         if (do_tail) begin
            if (req_text_byte == rtttl_pkg::CH_COMMA) begin
               emit = 1'b1;
            end else if (req_text_byte == rtttl_pkg::CH_DOT) begin
               pd_dot = 1'b1;
            end else if (is_digit) begin
               pd_oct = req_text_byte[3:0];
            end
         end
         if (ended && phase_in != rtttl_pkg::PH_DIGITS) begin
            emit = 1'b1;
         end
         if (emit) begin
            count_in = count_ff + CNT_W'(1);
            phase_in = rtttl_pkg::PH_DIGITS;
         end
         // end of piece restarts the parser
         if (ended) begin
            phase_in  = rtttl_pkg::PH_HEADER;
            colons_in = 2'd0;
            count_in  = '0;
         end
      end
      if (emit || ended) begin
         den_in    = '0;
         letter_in = 8'h00;
         sharp_in  = 1'b0;
         dot_in    = 1'b0;
         oct_in    = OCT_W'(4);
         if (ended && !emit && phase_ff == rtttl_pkg::PH_HEADER && skip_ff) begin
            phase_in = rtttl_pkg::PH_HEADER;
         end
      end else begin
         den_in    = pd_den;
         letter_in = pd_letter;
         sharp_in  = pd_sharp;
         dot_in    = pd_dot;
         oct_in    = pd_oct;
      end
   end

   // parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rtttl_pkg::PH_HEADER;
         colons_ff <= 2'd0;
         den_ff    <= '0;
         letter_ff <= 8'h00;
         sharp_ff  <= 1'b0;
         dot_ff    <= 1'b0;
         oct_ff    <= OCT_W'(4);
         count_ff  <= '0;
      end else if (req_valid && req_ready) begin
         phase_ff  <= phase_in;
         colons_ff <= colons_in;
         den_ff    <= den_in;
         letter_ff <= letter_in;
         sharp_ff  <= sharp_in;
         dot_ff    <= dot_in;
         oct_ff    <= oct_in;
         count_ff  <= count_in;
      end
   end

   // capture the note that is emitted
   always_ff @(posedge clock) begin
      if (req_valid && req_ready && emit) begin
         w_den_ff    <= pd_den;
         w_letter_ff <= pd_letter;
         w_sharp_ff  <= pd_sharp;
         w_dot_ff    <= pd_dot;
         w_oct_ff    <= pd_oct;
         w_num_ff    <= count_ff;
         w_end_ff    <= ended;
      end
   end

   // divider operands
   assign freq      = rtttl_pkg::pitch_hz(w_letter_ff, w_sharp_ff, w_oct_ff);
   assign tone_num  = NUM_W'(TONE_CLOCK_HZ) + NUM_W'(freq >> 1);
   assign den_eff   = (w_den_ff == '0) ? DEN_W'(4) : w_den_ff;
   assign beat_prod = 18'(tempo_ff) * 18'(den_eff);
   assign dur_div   = w_dot_ff ? {beat_prod, 1'b0} : {1'b0, beat_prod};
   assign dur_num   = w_dot_ff ? NUM_W'(DUR_NUM3) : NUM_W'(DUR_NUM1);
   assign quo_wide  = 64'(div_quo);

   // saturation of the two quotients
   assign period_sat = (freq == '0) ? '0 :
                       (quo_wide > 64'd131071) ? '1 : quo_wide[rtttl_pkg::PERIOD_W-1:0];
   assign ticks_sat  = (dur_div == '0) ? '1 :
                       (quo_wide > 64'hffff_ffff) ? '1 : quo_wide[rtttl_pkg::TICKS_W-1:0];

   rtttl_div #(
      .NW(NUM_W),
      .DW(DIV_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .quo(div_quo),
      .stat(div_stat)
   );

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtttl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer: tone division, then length division, then output load
   always_comb begin
      state_in   = state_ff;
      div_start  = 1'b0;
      div_num    = '0;
      div_den    = '0;
      cap_period = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         rtttl_pkg::ST_IDLE: begin
            if (req_valid && emit) begin
               state_in = rtttl_pkg::ST_TONE;
            end
         end
         rtttl_pkg::ST_TONE: begin
            div_start = 1'b1;
            div_num   = tone_num;
            div_den   = DIV_W'(freq);
            state_in  = rtttl_pkg::ST_TONE_WAIT;
         end
         rtttl_pkg::ST_TONE_WAIT: begin
            if (div_stat.done) begin
               cap_period = 1'b1;
               div_start  = 1'b1;
               div_num    = dur_num;
               div_den    = dur_div;
               state_in   = rtttl_pkg::ST_DUR_WAIT;
            end
         end
         rtttl_pkg::ST_DUR_WAIT: begin
            if (div_stat.done) begin
               state_in = rtttl_pkg::ST_LOAD;
            end
         end
         rtttl_pkg::ST_LOAD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = rtttl_pkg::ST_IDLE;
            end
         end
         default: state_in = rtttl_pkg::ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == rtttl_pkg::ST_IDLE);

   // waiting on either division
   assign div_wait = (state_ff == rtttl_pkg::ST_TONE_WAIT) ||
                     (state_ff == rtttl_pkg::ST_DUR_WAIT);

   // period holding register
   always_ff @(posedge clock) begin
      if (cap_period) begin
         period_ff <= period_sat;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_period_ff <= period_ff;
         rsp_ticks_ff  <= ticks_sat;
         rsp_rest_ff   <= (freq == '0);
         rsp_num_ff    <= w_num_ff;
         rsp_end_ff    <= w_end_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tone_period    = rsp_period_ff;
   assign rsp_duration_ticks = rsp_ticks_ff;
   assign rsp_is_rest        = rsp_rest_ff;
   assign rsp_note_number    = rsp_num_ff;
   assign rsp_piece_end      = rsp_end_ff;

   // checks
   `RTTTL_ASSERT_NEXT(a_emit_starts_tone, req_valid && req_ready && emit, state_ff == rtttl_pkg::ST_TONE)
   `RTTTL_ASSERT_IMP(a_div_free_at_start, div_start, !div_stat.busy)
   `RTTTL_ASSERT_IMP(a_done_while_waiting, div_stat.done, div_wait)
   `RTTTL_ASSERT_NEXT(a_load_shows_word, load_out, rsp_valid_ff && state_ff == rtttl_pkg::ST_IDLE)

endmodule

`default_nettype wire

// ===== bench/rtttl_note_parser_tb.sv =====
// ----------------------------------------------------------------------------
// rtttl_note_parser_tb
// Feeds ringtone score text through the note parser a word at a time. A
// scoreboard parses the same text, works out each note word and checks it.
// Both sides of the block idle and stall at random. The run covers tempo
// 0, 1 and 1023 and both header settings.
// ----------------------------------------------------------------------------

localparam longint unsigned TIMER_RATE = 64'd100_000_000;
localparam longint unsigned TONE_RATE  = 64'd6_250_000;
localparam logic [7:0]      CH_REST    = 8'h70;

// semitone frequencies in hz, octaves 2..7, c..b
localparam int unsigned NOTE_HZ [6][12] = '{
   '{65, 69, 73, 78, 82, 87, 93, 98, 104, 110, 117, 123},
   '{131, 139, 147, 156, 165, 175, 185, 196, 208, 220, 233, 247},
   '{262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494},
   '{523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988},
   '{1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976},
   '{2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951}
};

typedef struct packed {
   logic [rtttl_pkg::PERIOD_W-1:0] period;
   logic [rtttl_pkg::TICKS_W-1:0]  ticks;
   logic                           rest;
   logic [rtttl_pkg::COUNT_W-1:0]  number;
   logic                           piece_end;
} note_word_type;

class note_scoreboard;
   logic [rtttl_pkg::TEMPO_W-1:0]   bpm;
   logic                            skip_on;
   rtttl_pkg::parse_phase_type      phase;
   logic [1:0]                      colon_tally;
   logic [rtttl_pkg::DEN_W-1:0]     denom;
   logic [7:0]                      letter;
   logic                            sharp;
   logic                            dotted;
   logic [rtttl_pkg::OCT_W-1:0]     octave;
   logic [rtttl_pkg::COUNT_W-1:0]   note_count;
   note_word_type                   expected_notes[$];
   int                              mismatches;

   function new();
      bpm = 10'd120;
      skip_on = 1'b1;
      mismatches = 0;
      start_piece();
   endfunction

   function void drop_note();
      denom = '0;
      letter = '0;
      sharp = 1'b0;
      dotted = 1'b0;
      octave = 4'd4;
   endfunction

   function void start_piece();
      drop_note();
      phase = rtttl_pkg::PH_HEADER;
      colon_tally = 2'd0;
      note_count = '0;
   endfunction

   function void write_reg(input logic [rtttl_pkg::CSR_IDX_W-1:0] idx,
                           input logic [rtttl_pkg::TEMPO_W-1:0] data);
      if (idx == rtttl_pkg::CSR_TEMPO)
         bpm = data;
      else if (idx == rtttl_pkg::CSR_SKIP)
         skip_on = data[0];
   endfunction

   // bytes after the letter: comma closes the note, dot and digit modify it
   function logic tail_closes(input logic [7:0] b);
      if (b == rtttl_pkg::CH_COMMA)
         return 1'b1;
      if (b == rtttl_pkg::CH_DOT)
         dotted = 1'b1;
      else if (b >= rtttl_pkg::CH_ZERO && b <= rtttl_pkg::CH_NINE)
         octave = 4'(b - rtttl_pkg::CH_ZERO);
      return 1'b0;
   endfunction

   function int unsigned pitch_of();
      int semi;
      int oct;
      oct = octave;
      case (letter)
         rtttl_pkg::CH_C: semi = 0;
         rtttl_pkg::CH_D: semi = 2;
         rtttl_pkg::CH_E: semi = 4;
         rtttl_pkg::CH_F: semi = 5;
         rtttl_pkg::CH_G: semi = 7;
         rtttl_pkg::CH_A: semi = 9;
         rtttl_pkg::CH_B: semi = 11;
         default: return 0;
      endcase
      // b sharp rolls into c of the octave above
      if (sharp) begin
         semi++;
         if (semi >= 12) begin
            semi = 0;
            oct++;
         end
      end
      if (oct < 2 || oct > 7)
         return 0;
      return NOTE_HZ[oct-2][semi];
   endfunction

   // 240 s of timer ticks over bpm x denominator, dotted adds half
   function logic [31:0] ticks_of();
      longint unsigned num;
      longint unsigned div;
      longint unsigned q;
      num = TIMER_RATE * 64'd240;
      div = 64'(bpm) * ((denom == '0) ? 64'd4 : 64'(denom));
      if (dotted) begin
         num = num * 64'd3;
         div = div * 64'd2;
      end
      if (div == 0)
         return 32'hFFFF_FFFF;
      q = num / div;
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(q);
   endfunction

   // advance the parse by one accepted word, queue the note it closes
   function void parse_byte(input logic [7:0] b, input logic last);
      logic            ended;
      logic            emit;
      int unsigned     d;
      int unsigned     f;
      longint unsigned p;
      note_word_type   w;
      ended = (b == rtttl_pkg::CH_NUL) || last;
      emit = 1'b0;
      if (phase == rtttl_pkg::PH_HEADER) begin
         if (skip_on) begin
            if (ended) begin
               start_piece();
               return;
            end
            if (b == rtttl_pkg::CH_COLON) begin
               colon_tally = colon_tally + 2'd1;
               if (colon_tally >= 2'd2)
                  phase = rtttl_pkg::PH_DIGITS;
            end
            return;
         end
         phase = rtttl_pkg::PH_DIGITS;
      end
      if (b != rtttl_pkg::CH_NUL) begin
         case (phase)
            rtttl_pkg::PH_DIGITS: begin
               if (b >= rtttl_pkg::CH_ZERO && b <= rtttl_pkg::CH_NINE) begin
                  d = denom * 10 + (b - rtttl_pkg::CH_ZERO);
                  denom = (d > 255) ? 8'd255 : 8'(d);
               end else begin
                  letter = b;
                  phase = rtttl_pkg::PH_SHARP;
               end
            end
            rtttl_pkg::PH_SHARP: begin
               phase = rtttl_pkg::PH_TAIL;
               if (b == rtttl_pkg::CH_SHARP)
                  sharp = 1'b1;
               else
                  emit = tail_closes(b);
            end
            default: emit = tail_closes(b);
         endcase
      end
      if (ended && phase != rtttl_pkg::PH_DIGITS)
         emit = 1'b1;
      if (!emit) begin
         if (ended)
            start_piece();
         return;
      end

      f = pitch_of();
      if (letter == CH_REST)
         f = 0;
      w.period = '0;
      if (f != 0) begin
         p = (TONE_RATE + f / 2) / f;
         w.period = (p > 64'd131071) ? 17'h1FFFF : 17'(p);
      end
      w.ticks = ticks_of();
      w.rest = (f == 0);
      w.number = note_count;
      w.piece_end = ended;
      expected_notes.push_back(w);

      note_count = note_count + 1'b1;
      drop_note();
      phase = rtttl_pkg::PH_DIGITS;
      if (ended)
         start_piece();
   endfunction

   function void check_note(input note_word_type got);
      note_word_type want;
      if (expected_notes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] note word with none expected", $time);
            $display("   actual   period %0d ticks %0d rest %0b number %0d end %0b",
                     got.period, got.ticks, got.rest, got.number, got.piece_end);
         end
         return;
      end
      want = expected_notes.pop_front();
      if (got.period !== want.period || got.ticks !== want.ticks ||
          got.rest !== want.rest || got.number !== want.number ||
          got.piece_end !== want.piece_end) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] note word mismatch", $time);
            $display("   expected period %0d ticks %0d rest %0b number %0d end %0b",
                     want.period, want.ticks, want.rest, want.number, want.piece_end);
            $display("   actual   period %0d ticks %0d rest %0b number %0d end %0b",
                     got.period, got.ticks, got.rest, got.number, got.piece_end);
         end
      end
   endfunction
endclass

module rtttl_note_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES     = 600;
   localparam int SETTLE_CYCLES   = 100;   // above the note latency
   localparam int QUIET_LIMIT     = 5000;
   localparam int ITEMS_PER_PHASE = 150;

   logic                                 clock;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [7:0]                           req_text_byte = '0;
   logic                                 req_last_byte = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [rtttl_pkg::PERIOD_W-1:0]       rsp_tone_period;
   logic [rtttl_pkg::TICKS_W-1:0]        rsp_duration_ticks;
   logic                                 rsp_is_rest;
   logic [rtttl_pkg::COUNT_W-1:0]        rsp_note_number;
   logic                                 rsp_piece_end;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [rtttl_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [rtttl_pkg::TEMPO_W-1:0]        csr_wdata = '0;

   note_scoreboard board = new();
   bit send_idling = 1'b0;
   bit recv_idling = 1'b0;
   int hold_requests = 0;
   int holds_done = 0;
   int items_sent = 0;

   rtttl_note_parser uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [7:0] pick_letter();
      case ($urandom_range(0, 7))
         0: return rtttl_pkg::CH_A;
         1: return rtttl_pkg::CH_B;
         2: return rtttl_pkg::CH_C;
         3: return rtttl_pkg::CH_D;
         4: return rtttl_pkg::CH_E;
         5: return rtttl_pkg::CH_F;
         6: return rtttl_pkg::CH_G;
         default: return CH_REST;
      endcase
   endfunction

   // accepted words go to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_note(note_word_type'{rsp_tone_period, rsp_duration_ticks,
                                             rsp_is_rest, rsp_note_number, rsp_piece_end});
         if (csr_valid && csr_ready)
            board.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready)
            board.parse_byte(req_text_byte, req_last_byte);
      end
   end

   // end the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // note receiver: random stalls plus requested long hold-offs
   initial begin : receiver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (recv_idling && $urandom_range(0, 3) == 0) begin
            stall_left = gap_length() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // one text word, with an optional idle gap ahead of it
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = (send_idling && $urandom_range(0, 2) == 0) ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_text(input string s, input logic last_on_end);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], last_on_end && (i == s.len() - 1));
   endtask

   // stop sending until every note word is back and the block is quiet
   task automatic wait_for_notes();
      req_valid <= 1'b0;
      // let the monitor log the last accepted word first
      @(posedge clock);
      while (board.expected_notes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [rtttl_pkg::TEMPO_W-1:0] bpm, input logic skip);
      wait_for_notes();
      csr_valid <= 1'b1;
      csr_index <= rtttl_pkg::CSR_TEMPO;
      csr_wdata <= bpm;
      do @(posedge clock); while (!csr_ready);
      csr_index <= rtttl_pkg::CSR_SKIP;
      csr_wdata <= rtttl_pkg::TEMPO_W'(skip);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one random piece: header when skipping, then notes, then an end mark; now and then pure noise instead
   task automatic send_piece();
      logic [7:0] text[$];
      string      hdr_chars;
      int         n_notes;
      int         r;
      int         keep;
      hdr_chars = "dob=,0123456789";
      if ($urandom_range(0, 19) == 0) begin
         // pure noise
         repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(1, 255)));
      end else begin
         if (board.skip_on) begin
            repeat ($urandom_range(0, 6))
               text.push_back(rtttl_pkg::CH_A + 8'($urandom_range(0, 25)));
            text.push_back(rtttl_pkg::CH_COLON);
            repeat ($urandom_range(0, 8)) text.push_back(hdr_chars[$urandom_range(0, 14)]);
            text.push_back(rtttl_pkg::CH_COLON);
         end
         n_notes = $urandom_range(1, 10);
         for (int k = 0; k < n_notes; k++) begin
            r = $urandom_range(0, 9);
            if (r >= 4 && r <= 7) begin
               case ($urandom_range(0, 5))
                  0: text.push_back("1");
                  1: text.push_back("2");
                  2: text.push_back("4");
                  3: text.push_back("8");
                  4: begin text.push_back("1"); text.push_back("6"); end
                  default: begin text.push_back("3"); text.push_back("2"); end
               endcase
            end else if (r == 8) begin
               repeat ($urandom_range(1, 4))
                  text.push_back(rtttl_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end else if (r == 9) begin
               text.push_back(rtttl_pkg::CH_ZERO);
            end
            if ($urandom_range(0, 19) < 17)
               text.push_back(pick_letter());
            else
               text.push_back(8'($urandom_range(1, 255)));
            if ($urandom_range(0, 9) < 3)
               text.push_back(rtttl_pkg::CH_SHARP);
            repeat ($urandom_range(0, 3)) begin
               r = $urandom_range(0, 19);
               if (r < 6)
                  text.push_back(rtttl_pkg::CH_DOT);
               else if (r < 16)
                  text.push_back(rtttl_pkg::CH_ZERO + 8'($urandom_range(4, 7)));
               else if (r < 19)
                  text.push_back(rtttl_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
               else
                  text.push_back(8'($urandom_range(1, 255)));
            end
            if (k != n_notes - 1)
               text.push_back(rtttl_pkg::CH_COMMA);
         end
         // broken piece: cut short anywhere
         if ($urandom_range(0, 9) == 0 && text.size() > 1) begin
            keep = $urandom_range(1, text.size() - 1);
            while (text.size() > keep) void'(text.pop_back());
         end
      end
      r = $urandom_range(0, 4);
      if (r >= 2)
         text.push_back(rtttl_pkg::CH_NUL);
      for (int i = 0; i < text.size(); i++)
         send_byte(text[i], (r != 2 && r != 3) && (i == text.size() - 1));
   endtask

   initial begin : stimulus
      int target;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, header skipped up to the second colon
      send_text("::999b#7,", 1'b0);          // saturated denominator, b sharp past octave 7
      send_text("c.2,", 1'b0);               // dotted, lowest octave
      send_text("p,", 1'b0);                 // rest
      send_text(",,", 1'b0);                 // comma taken as the letter
      send_byte(8'hFF, 1'b0);                // unknown letter closed by a nul
      send_byte(rtttl_pkg::CH_NUL, 1'b0);
      send_byte("x", 1'b1);                  // end while still in the header
      send_text("::4", 1'b0);                // end before any letter
      send_byte(rtttl_pkg::CH_NUL, 1'b0);
      send_text("::16a#9", 1'b1);            // bad octave closed by the last flag

      // random phases over the register settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_config(10'd1023, 1'b0);
            1: set_config(10'd1, 1'b1);
            2: set_config(10'd0, 1'b1);
            3: set_config(10'($urandom_range(1, 1023)), 1'b0);
            4: set_config(10'($urandom_range(1, 1023)), 1'b1);
            default: set_config(10'd120, 1'b1);
         endcase
         send_idling = (ph != 1 && ph != 4);
         recv_idling = (ph != 1 && ph != 3);
         // long receiver hold while text keeps coming
         if (ph == 1 || ph == 5)
            hold_requests++;
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target)
            send_piece();
      end

      wait_for_notes();
      if (board.mismatches == 0 && board.expected_notes.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
